[hdl/zigzag_leb128_codec_defines.svh]
// ----------------------------------------------------------------------------
// zigzag_leb128_codec_defines
// Assertion macros shared by the codec RTL.
// ----------------------------------------------------------------------------
`ifndef ZIGZAG_LEB128_CODEC_DEFINES_SVH
`define ZIGZAG_LEB128_CODEC_DEFINES_SVH

// checked only outside reset
`define ZLC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ZLC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/zlc_pkg.sv]
// ----------------------------------------------------------------------------
// zlc_pkg
// Types and constants of the zigzag LEB128 codec.
// ----------------------------------------------------------------------------
`default_nettype none

package zlc_pkg;

   typedef enum logic [1:0] {
      MODE_ENCODE = 2'd0,
      MODE_DECODE = 2'd1,
      MODE_END    = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_WPE = 2'd1,
      ST_DEC = 2'd2
   } status_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_ENCODE
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic enc_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic enc_ok;
      logic enc_last;
   } dp_status_type;

   localparam logic [3:0] LAST_GROUP = 4'd9;

endpackage

`default_nettype wire

[hdl/zlc_ctrl.sv]
// ----------------------------------------------------------------------------
// zlc_ctrl
// Sequencer: takes items and steps the byte emitter during an encode.
// ----------------------------------------------------------------------------
`default_nettype none

module zlc_ctrl
   import zlc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [1:0]    req_tuser,
   input  wire dp_status_type stat,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   mode_type       mode;

   assign mode = mode_type'(req_tuser);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTRL_IDLE: begin
            if (req_tvalid && stat.out_free && mode == MODE_ENCODE && stat.enc_ok) begin
               state_in = CTRL_ENCODE;
            end
         end
         CTRL_ENCODE: begin
            if (stat.out_free && stat.enc_last) begin
               state_in = CTRL_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd.accept   = 1'b0;
      cmd.enc_step = 1'b0;
      unique case (state_ff)
         CTRL_IDLE: begin
            req_tready = stat.out_free;
            cmd.accept = req_tvalid && stat.out_free;
         end
         CTRL_ENCODE: begin
            cmd.enc_step = stat.out_free;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hdl/zlc_dp.sv]
// ----------------------------------------------------------------------------
// zlc_dp
// Datapath: stream state, decode accumulator, encode shifter, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module zlc_dp
   import zlc_pkg::*;
#(
   parameter int SIZE_BITS = 16
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [SIZE_BITS-1:0] csr_wdata,
   input  wire logic [71:0]          req_tdata,
   input  wire logic [1:0]           req_tuser,
   input  wire ctrl_cmd_type         cmd,
   output dp_status_type             stat,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output logic [79:0]               rsp_tdata,
   output logic [1:0]                rsp_tuser,
   output logic                      rsp_tlast
);

   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [SIZE_BITS:0]   pos_ff, pos_in;
   status_type           status_ff, status_in;
   logic [63:0]          acc_ff, acc_in;
   logic [3:0]           grp_ff, grp_in;
   logic [63:0]          shift_ff, shift_in;

   logic                 ovalid_ff, ovalid_in;
   logic [7:0]           obyte_ff, obyte_in;
   logic                 obv_ff, obv_in;
   logic [63:0]          oval_ff, oval_in;
   logic                 ovv_ff, ovv_in;
   status_type           ostat_ff, ostat_in;
   logic                 olast_ff, olast_in;

   mode_type             mode;
   logic                 full;
   logic                 sticky;
   logic [SIZE_BITS:0]   pos_inc;
   logic [63:0]          value_in;
   logic [7:0]           dbyte;
   logic [5:0]           sh;
   logic [63:0]          merged;
   logic [63:0]          dec_val;
   logic [63:0]          zz;
   logic [63:0]          rest;
   logic                 cont;

   assign mode     = mode_type'(req_tuser);
   assign value_in = req_tdata[63:0];
   assign dbyte    = req_tdata[71:64];
   assign full     = pos_ff >= {1'b0, size_ff};
   assign sticky   = status_ff != ST_OK;
   assign pos_inc  = pos_ff + {{SIZE_BITS{1'b0}}, 1'b1};

   assign sh      = {2'b00, grp_ff} * 6'd7;
   assign merged  = acc_ff | ({57'd0, dbyte[6:0]} << sh);
   assign dec_val = {1'b0, merged[63:1]} ^ {64{merged[0]}};
   assign zz      = {value_in[62:0], 1'b0} ^ {64{value_in[63]}};

   assign rest = {7'd0, shift_ff[63:7]};
   assign cont = rest != 64'd0;

   assign stat.out_free = !ovalid_ff || rsp_tready;
   assign stat.enc_ok   = !sticky;
   assign stat.enc_last = full || !cont;

   always_comb begin
      size_in   = size_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      acc_in    = acc_ff;
      grp_in    = grp_ff;
      shift_in  = shift_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      obyte_in  = obyte_ff;
      obv_in    = obv_ff;
      oval_in   = oval_ff;
      ovv_in    = ovv_ff;
      ostat_in  = ostat_ff;
      olast_in  = olast_ff;

      if (csr_we) begin
         size_in = csr_wdata;
      end

      if (cmd.accept) begin
         ovalid_in = 1'b1;
         obyte_in  = 8'd0;
         obv_in    = 1'b0;
         oval_in   = 64'd0;
         ovv_in    = 1'b0;
         ostat_in  = status_ff;
         olast_in  = 1'b1;
         unique case (mode)
            MODE_CLEAR: begin
               pos_in    = '0;
               status_in = ST_OK;
               acc_in    = 64'd0;
               grp_in    = 4'd0;
               ostat_in  = ST_OK;
            end
            MODE_ENCODE: begin
               if (!sticky) begin
                  ovalid_in = ovalid_ff && !rsp_tready;
                  acc_in    = 64'd0;
                  grp_in    = 4'd0;
                  shift_in  = zz;
               end
            end
            MODE_DECODE: begin
               if (!sticky) begin
                  if (full) begin
                     status_in = ST_DEC;
                     ostat_in  = ST_DEC;
                     acc_in    = 64'd0;
                     grp_in    = 4'd0;
                  end else begin
                     pos_in = pos_inc;
                     if (!dbyte[7]) begin
                        acc_in  = 64'd0;
                        grp_in  = 4'd0;
                        oval_in = dec_val;
                        ovv_in  = 1'b1;
                     end else if (grp_ff == LAST_GROUP) begin
                        status_in = ST_DEC;
                        ostat_in  = ST_DEC;
                        acc_in    = 64'd0;
                        grp_in    = 4'd0;
                     end else begin
                        acc_in = merged;
                        grp_in = grp_ff + 4'd1;
                     end
                  end
               end
            end
            MODE_END: begin
               if (!sticky && grp_ff != 4'd0) begin
                  status_in = ST_DEC;
                  ostat_in  = ST_DEC;
                  acc_in    = 64'd0;
                  grp_in    = 4'd0;
               end
            end
         endcase
      end

      if (cmd.enc_step) begin
         ovalid_in = 1'b1;
         oval_in   = 64'd0;
         ovv_in    = 1'b0;
         if (full) begin
            status_in = ST_WPE;
            obyte_in  = 8'd0;
            obv_in    = 1'b0;
            ostat_in  = ST_WPE;
            olast_in  = 1'b1;
         end else begin
            pos_in   = pos_inc;
            shift_in = rest;
            obyte_in = {cont, shift_ff[6:0]};
            obv_in   = 1'b1;
            ostat_in = status_ff;
            olast_in = !cont;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= '0;
         pos_ff    <= '0;
         status_ff <= ST_OK;
         acc_ff    <= 64'd0;
         grp_ff    <= 4'd0;
         ovalid_ff <= 1'b0;
      end else begin
         size_ff   <= size_in;
         pos_ff    <= pos_in;
         status_ff <= status_in;
         acc_ff    <= acc_in;
         grp_ff    <= grp_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      obyte_ff <= obyte_in;
      obv_ff   <= obv_in;
      oval_ff  <= oval_in;
      ovv_ff   <= ovv_in;
      ostat_ff <= ostat_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {6'd0, 2'(ostat_ff), oval_ff, obyte_ff};
   assign rsp_tuser  = {ovv_ff, obv_ff};
   assign rsp_tlast  = olast_ff;

endmodule

`default_nettype wire

[hdl/zigzag_leb128_codec.sv]
// ----------------------------------------------------------------------------
// zigzag_leb128_codec
// Signed 64-bit zigzag LEB128 encoder/decoder on a size-bounded byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: mode in req_tuser, value and byte in req_tdata.
//   rsp_* returns the results of an item; rsp_tlast marks its final result.
//   csr_we/csr_wdata set the stream size; write only while the block is idle.
// Sequencing and throughput:
//   Decode, end of data and clear results appear in the output register in
//   the cycle after the item is taken.
//   Encode loads the shifter, then emits one byte (1 to 10 in all) per cycle
//   while the output register is free or being read; the byte emitter is the limit.
//   A new item is taken once the encode shifter is empty and the output
//   register is free or being read.
// Reset:
//   Clears position, status, partial value, stream size and the output valid.
// Backpressure:
//   With rsp_tready low the output register holds its item and the block
//   stops both emitting bytes and taking items until it is read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "zigzag_leb128_codec_defines.svh"

module zigzag_leb128_codec
   import zlc_pkg::*;
#(
   parameter int SIZE_BITS = 16
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [SIZE_BITS-1:0] csr_wdata,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [71:0]          req_tdata,   // value_in[63:0], byte_in[71:64]
   input  wire logic [1:0]           req_tuser,   // mode[1:0]
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [79:0]               rsp_tdata,   // byte_out[7:0], value_out[71:8],
                                                  // status[73:72], zero[79:74]
   output logic [1:0]                rsp_tuser,   // byte_valid[0], value_valid[1]
   output logic                      rsp_tlast
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   zlc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   zlc_dp #(
      .SIZE_BITS (SIZE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `ZLC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "output valid after reset")
   `ZLC_ASSERT(a_no_take_while_emit, !(req_tready && cmd.enc_step),
      "item taken during byte emission")
   `ZLC_ASSERT(a_one_kind, rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]),
      "byte and value both flagged")
   `ZLC_ASSERT(a_status_code, rsp_tvalid |-> (rsp_tdata[73:72] != 2'b11),
      "undefined status code")

endmodule

`default_nettype wire

[tb/zigzag_leb128_codec_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zigzag_leb128_codec_tb
// Self-checking bench for the zigzag LEB128 codec.
// Directed items cover the value extremes, every mode, sticky errors, a
// full stream on encode and on decode, a shrunk stream size, the tenth
// group cases and end of data with a partial value. Random mixes of
// encodes, byte runs, end-of-data and clears follow under three idle
// profiles. Each taken item is run through a local codec predictor, and
// every result is compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module zigzag_leb128_codec_tb;
   import zlc_pkg::*;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic        byte_valid;
      logic [63:0] value_out;
      logic        value_valid;
      status_type  status;
      logic        last;
   } codec_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // value_in[63:0], byte_in[71:64]
   logic [1:0]  req_tuser = '0;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // byte_out[7:0], value_out[71:8], status[73:72]
   logic [1:0]  rsp_tuser;        // byte_valid[0], value_valid[1]
   logic        rsp_tlast;

   // predicted codec state
   logic [15:0] size_q;
   logic [16:0] pos_q;
   status_type  err_q;
   logic [63:0] acc_q;
   logic [3:0]  groups_q;

   codec_rsp_type rsp_due[$];
   codec_rsp_type rsp_want;
   codec_rsp_type rsp_got;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_total = 0;
   int items_ignored = 0;
   int results_checked = 0;
   int mismatches = 0;

   zigzag_leb128_codec #(
      .SIZE_BITS (16)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** zigzag_leb128_codec: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   task automatic push_rsp(logic [7:0] b, logic bv, logic [63:0] val, logic vv, logic lst);
      codec_rsp_type r;
      r.byte_out    = b;
      r.byte_valid  = bv;
      r.value_out   = val;
      r.value_valid = vv;
      r.status      = err_q;
      r.last        = lst;
      rsp_due.push_back(r);
   endtask

   task automatic leb128_predict(mode_type m, logic [63:0] v, logic [7:0] b);
      logic [63:0] zz;
      logic [6:0]  grp;
      logic        more;
      int          sh;
      if (m == MODE_CLEAR) begin
         pos_q    = '0;
         err_q    = ST_OK;
         acc_q    = '0;
         groups_q = '0;
         push_rsp(8'h00, 1'b0, 64'd0, 1'b0, 1'b1);
         return;
      end
      if (err_q != ST_OK) begin
         push_rsp(8'h00, 1'b0, 64'd0, 1'b0, 1'b1);
         return;
      end
      case (m)
         MODE_ENCODE: begin
            acc_q    = '0;
            groups_q = '0;
            zz = {v[62:0], 1'b0} ^ {64{v[63]}};
            do begin
               grp  = zz[6:0];
               zz   = zz >> 7;
               more = (zz != 64'd0);
               if (pos_q >= {1'b0, size_q}) begin
                  err_q = ST_WPE;
                  push_rsp(8'h00, 1'b0, 64'd0, 1'b0, 1'b1);
                  return;
               end
               pos_q = pos_q + 17'd1;
               push_rsp({more, grp}, 1'b1, 64'd0, 1'b0, !more);
            end while (more);
         end
         MODE_DECODE: begin
            if (pos_q >= {1'b0, size_q}) begin
               err_q    = ST_DEC;
               acc_q    = '0;
               groups_q = '0;
               push_rsp(8'h00, 1'b0, 64'd0, 1'b0, 1'b1);
            end else begin
               pos_q = pos_q + 17'd1;
               sh    = (7 * groups_q) & 63;
               acc_q = acc_q | ({57'd0, b[6:0]} << sh);
               if (!b[7]) begin
                  push_rsp(8'h00, 1'b0, (acc_q >> 1) ^ {64{acc_q[0]}}, 1'b1, 1'b1);
                  acc_q    = '0;
                  groups_q = '0;
               end else begin
                  groups_q = groups_q + 4'd1;
                  if (groups_q >= 4'd10) begin
                     err_q    = ST_DEC;
                     acc_q    = '0;
                     groups_q = '0;
                  end
                  push_rsp(8'h00, 1'b0, 64'd0, 1'b0, 1'b1);
               end
            end
         end
         default: begin
            if (groups_q != 4'd0) begin
               err_q    = ST_DEC;
               acc_q    = '0;
               groups_q = '0;
            end
            push_rsp(8'h00, 1'b0, 64'd0, 1'b0, 1'b1);
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_got.byte_out    = rsp_tdata[7:0];
         rsp_got.value_out   = rsp_tdata[71:8];
         rsp_got.status      = status_type'(rsp_tdata[73:72]);
         rsp_got.byte_valid  = rsp_tuser[0];
         rsp_got.value_valid = rsp_tuser[1];
         rsp_got.last        = rsp_tlast;
         if (rsp_due.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h", $time, rsp_got);
            mismatches++;
         end else begin
            rsp_want = rsp_due.pop_front();
            check_field("byte_out", 64'(rsp_want.byte_out), 64'(rsp_got.byte_out));
            check_field("byte_valid", 64'(rsp_want.byte_valid), 64'(rsp_got.byte_valid));
            check_field("value_out", rsp_want.value_out, rsp_got.value_out);
            check_field("value_valid", 64'(rsp_want.value_valid),
                        64'(rsp_got.value_valid));
            check_field("status", 64'(rsp_want.status), 64'(rsp_got.status));
            check_field("last", 64'(rsp_want.last), 64'(rsp_got.last));
            results_checked++;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_item(mode_type m, logic [63:0] v, logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {b, v};
      do @(posedge clock); while (!req_tready);
      if (err_q != ST_OK && m != MODE_CLEAR)
         items_ignored++;
      items_total++;
      leb128_predict(m, v, b);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_stream_size(logic [15:0] size);
      wait_results_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(negedge clock);
      csr_we    <= 1'b0;
      size_q = size;
   endtask

   // n decode items; all but the last carry a continuation bit unless open
   task automatic send_byte_run(int n, bit terminate);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = {(i < n - 1) || !terminate, 7'($urandom)};
         send_item(MODE_DECODE, {$urandom, $urandom}, b);
      end
   endtask

   function automatic logic [63:0] rand_value();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return $signed(raw) >>> $urandom_range(0, 63);
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_empty_stream();
      write_stream_size(16'd0);
      send_item(MODE_ENCODE, 64'd5, 8'h00);
      send_item(MODE_DECODE, 64'd0, 8'h00);
      send_item(MODE_CLEAR, 64'd0, 8'h00);
      send_item(MODE_DECODE, 64'd0, 8'h00);
      send_item(MODE_CLEAR, 64'd0, 8'h00);
   endtask

   task automatic test_encode_extremes();
      write_stream_size(16'hFFFF);
      send_item(MODE_ENCODE, 64'd0, 8'hFF);
      send_item(MODE_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
      send_item(MODE_ENCODE, 64'd64, 8'h00);
      send_item(MODE_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
      send_item(MODE_ENCODE, 64'h8000_0000_0000_0000, 8'h00);
   endtask

   task automatic test_decode_specials();
      send_item(MODE_DECODE, 64'd0, 8'h7F);
      // terminating tenth group, its bits above 63 dropped
      for (int i = 0; i < 9; i++)
         send_item(MODE_DECODE, 64'd0, 8'hFF);
      send_item(MODE_DECODE, 64'd0, 8'h7F);
      // encode drops a partial value
      send_item(MODE_DECODE, 64'd0, 8'h85);
      send_item(MODE_ENCODE, 64'd1, 8'h00);
      // end of data with a partial value, then sticky
      send_item(MODE_DECODE, 64'd0, 8'h80);
      send_item(MODE_END, 64'd0, 8'h00);
      send_item(MODE_END, 64'd0, 8'h00);
      send_item(MODE_CLEAR, 64'd0, 8'h00);
      send_item(MODE_END, 64'd0, 8'h00);
      // tenth group still continued
      for (int i = 0; i < 10; i++)
         send_item(MODE_DECODE, 64'd0, 8'h80);
      send_item(MODE_CLEAR, 64'd0, 8'h00);
   endtask

   task automatic test_stream_full();
      write_stream_size(16'd3);
      send_item(MODE_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
      send_item(MODE_CLEAR, 64'd0, 8'h00);
      send_item(MODE_ENCODE, 64'd300, 8'h00);
      // shrink below the current position
      write_stream_size(16'd1);
      send_item(MODE_DECODE, 64'd0, 8'h00);
      send_item(MODE_CLEAR, 64'd0, 8'h00);
   endtask

   task automatic run_random_mix(int n_items);
      int start;
      int pick;
      start = items_total;
      while (items_total - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_item(MODE_ENCODE, rand_value(), 8'($urandom));
         else if (pick < 75)
            send_byte_run($urandom_range(1, 10), 1'b1);
         else if (pick < 82) begin
            send_byte_run($urandom_range(1, 9), 1'b0);
            if ($urandom_range(1))
               send_item(MODE_END, {$urandom, $urandom}, 8'($urandom));
            else
               send_item(MODE_ENCODE, rand_value(), 8'($urandom));
         end else if (pick < 85)
            send_byte_run(10, 1'b0);
         else if (pick < 92)
            send_item(MODE_END, {$urandom, $urandom}, 8'($urandom));
         else
            send_item(MODE_CLEAR, {$urandom, $urandom}, 8'($urandom));
      end
   endtask

   task automatic run_random_phase(int send_pct, int recv_pct, logic [15:0] size_a,
                                   logic [15:0] size_b, int n_items);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_stream_size(size_a);
      send_item(MODE_CLEAR, 64'd0, 8'h00);
      run_random_mix(n_items / 2);
      write_stream_size(size_b);
      send_item(MODE_CLEAR, 64'd0, 8'h00);
      run_random_mix(n_items - n_items / 2);
   endtask

   initial begin
      size_q   = '0;
      pos_q    = '0;
      err_q    = ST_OK;
      acc_q    = '0;
      groups_q = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_idle_pct = 87;
      test_empty_stream();
      test_encode_extremes();
      test_decode_specials();
      test_stream_full();
      run_random_phase(16, 87, 16'hFFFF, 16'd48, 104);
      run_random_phase(87, 16, 16'd400, 16'd7, 104);
      run_random_phase(0, 0, 16'($urandom_range(16, 4000)), 16'hFFFF, 104);

      wait_results_drained();
      repeat (16) @(posedge clock);
      $display("Sent %0d items (%0d ignored under sticky status), checked %0d results.",
               items_total, items_ignored, results_checked);
      $display("Covered all modes, full stream, tenth group cases and three idle mixes.");
      if (mismatches == 0)
         $display("** zigzag_leb128_codec: PASSED **");
      else
         $display("** zigzag_leb128_codec: FAILED **");
      $finish;
   end

endmodule
